// ===== src/prms_pkg.sv =====
// ----------------------------------------------------------------------------
// prms_pkg: shared types and constants of the mid pseudo-rank stream
// Field widths of the sample and result channels, the configuration
// register map and the result record.
// ----------------------------------------------------------------------------
package prms_pkg;

  localparam int unsigned VALUE_W  = 32;
  localparam int unsigned LABEL_W  = 3;
  localparam int unsigned RANK_W   = 32;
  localparam int unsigned LENGTH_W = 16;
  localparam int unsigned COUNT_W  = 16;
  localparam int unsigned GCOUNT_W = 3;
  localparam int unsigned CFG_AW   = 3;
  localparam int unsigned CFG_DW   = 16;
  localparam int unsigned NUM_SIZE_REGS = 6;

  // Configuration register indexes
  localparam logic [CFG_AW-1:0] REG_TOTAL_COUNT  = 3'd0;
  localparam logic [CFG_AW-1:0] REG_GROUP_COUNT  = 3'd1;
  localparam logic [CFG_AW-1:0] REG_GROUP_SIZE_0 = 3'd2;
  localparam logic [CFG_AW-1:0] REG_GROUP_SIZE_1 = 3'd3;
  localparam logic [CFG_AW-1:0] REG_GROUP_SIZE_2 = 3'd4;
  localparam logic [CFG_AW-1:0] REG_GROUP_SIZE_3 = 3'd5;
  localparam logic [CFG_AW-1:0] REG_GROUP_SIZE_4 = 3'd6;
  localparam logic [CFG_AW-1:0] REG_GROUP_SIZE_5 = 3'd7;

  localparam logic [RANK_W-1:0] ALL_ONES = '1;

  // One result: the mid pseudo-rank of a closed tie run
  typedef struct packed {
    logic [RANK_W-1:0]   pseudo_rank;
    logic [LENGTH_W-1:0] run_length;
    logic                end_of_stream;
  } result_t;

endpackage

// ===== src/prms_if.sv =====
// ----------------------------------------------------------------------------
// prms_if: sample and result channels of the mid pseudo-rank stream
// Valid/ready channels; a transfer happens when valid and ready are high.
// ----------------------------------------------------------------------------
interface prms_in_if
  import prms_pkg::*;
();
  logic               valid;
  logic               ready;
  logic [VALUE_W-1:0] sample_value;
  logic [LABEL_W-1:0] group_label;
  logic               last;

  modport source (output valid, sample_value, group_label, last, input ready);
  modport sink   (input valid, sample_value, group_label, last, output ready);
endinterface

interface prms_out_if
  import prms_pkg::*;
();
  logic                valid;
  logic                ready;
  logic [RANK_W-1:0]   pseudo_rank;
  logic [LENGTH_W-1:0] run_length;
  logic                end_of_stream;

  modport source (output valid, pseudo_rank, run_length, end_of_stream, input ready);
  modport sink   (input valid, pseudo_rank, run_length, end_of_stream, output ready);
endinterface

// ===== src/pseudo_rank_midrank_stream.sv =====
// A result passes the input register and the result queue after the sample that closes its run;
// a sample waits in the input register while the queue lacks room for two results.
// Throughput: one sample per cycle unless stalled; a sample closing two runs pushes two results.
// Group weights come from a bit-serial restoring divider, one quotient bit per cycle.
// After a configuration write the sample input stalls until all group weights are recomputed.
// Reset: registers read 1, weights hold the value for N=G=n=1, no run is open.
// ----------------------------------------------------------------------------
// pseudo_rank_midrank_stream: mid pseudo-ranks of tie runs in a sorted stream
// Accumulates group weights N/(G*n_g) over runs of equal sample values and
// emits prior sum + half run weight + 0.5 for every closed run.
// ----------------------------------------------------------------------------
module pseudo_rank_midrank_stream
  import prms_pkg::*;
#(
  parameter int unsigned MAX_GROUPS    = 6,
  parameter int unsigned MAX_SAMPLES   = 65535,
  parameter int unsigned FRACTION_BITS = 16
) (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  logic                 cfg_we_i,
  input  logic [CFG_AW-1:0]    cfg_addr_i,
  input  logic [CFG_DW-1:0]    cfg_wdata_i,
  prms_in_if.sink              in_ch,
  prms_out_if.source           out_ch
);

  localparam int unsigned GIW  = (MAX_GROUPS > 1) ? $clog2(MAX_GROUPS) : 1;
  localparam int unsigned DW   = COUNT_W + FRACTION_BITS;     // dividend width
  localparam int unsigned QW   = (DW > 32) ? DW : 33;         // quotient register width
  localparam int unsigned DVW  = GCOUNT_W + COUNT_W;          // divisor width
  localparam int unsigned RW   = DVW + 1;                     // partial remainder width
  localparam int unsigned CW   = $clog2(DW + 1);
  localparam int unsigned FD   = 4;                           // result queue depth
  localparam int unsigned FPW  = $clog2(FD);
  localparam logic [RANK_W-1:0]   HALF      = RANK_W'(1) << (FRACTION_BITS - 1);
  localparam logic [RANK_W-1:0]   UNIT_W    = RANK_W'(1) << FRACTION_BITS;
  localparam logic [LENGTH_W-1:0] RUN_LIMIT = LENGTH_W'(MAX_SAMPLES);

  typedef enum logic [1:0] {
    W_IDLE,
    W_LOAD,
    W_DIV
  } wstate_e;

  // Saturating 32-bit add
  function automatic logic [RANK_W-1:0] sat_add(input logic [RANK_W-1:0] a,
                                                input logic [RANK_W-1:0] b);
    logic [RANK_W:0] s;
    s = {1'b0, a} + {1'b0, b};
    return s[RANK_W] ? ALL_ONES : s[RANK_W-1:0];
  endfunction

  // Mid pseudo-rank of a run: prior + weight/2 + 0.5, saturated
  function automatic logic [RANK_W-1:0] mid_rank(input logic [RANK_W-1:0] prior,
                                                 input logic [RANK_W-1:0] weight);
    logic [RANK_W+1:0] s;
    s = {2'b00, prior} + {3'b000, weight[RANK_W-1:1]} + {2'b00, HALF};
    return (|s[RANK_W+1:RANK_W]) ? ALL_ONES : s[RANK_W-1:0];
  endfunction

  // --------------------------------------------------------------------------
  // Configuration registers
  // --------------------------------------------------------------------------
  logic [COUNT_W-1:0]  total_count_q;
  logic [GCOUNT_W-1:0] group_count_q;
  logic [COUNT_W-1:0]  group_size_q [NUM_SIZE_REGS];
  logic [CFG_AW-1:0]   size_idx;

  assign size_idx = cfg_addr_i - REG_GROUP_SIZE_0;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      total_count_q <= COUNT_W'(1);
      group_count_q <= GCOUNT_W'(1);
      for (int i = 0; i < NUM_SIZE_REGS; i++) begin
        group_size_q[i] <= COUNT_W'(1);
      end
    end else if (cfg_we_i) begin
      unique case (cfg_addr_i) inside
        REG_TOTAL_COUNT: total_count_q <= cfg_wdata_i;
        REG_GROUP_COUNT: group_count_q <= cfg_wdata_i[GCOUNT_W-1:0];
        REG_GROUP_SIZE_0, REG_GROUP_SIZE_1, REG_GROUP_SIZE_2,
        REG_GROUP_SIZE_3, REG_GROUP_SIZE_4, REG_GROUP_SIZE_5: begin
          group_size_q[size_idx] <= cfg_wdata_i;
        end
        default: ;
      endcase
    end
  end

  // --------------------------------------------------------------------------
  // Group weight recompute: one group at a time, one quotient bit per cycle
  // --------------------------------------------------------------------------
  wstate_e          wst_q;
  logic [GIW-1:0]   grp_q;
  logic [DVW-1:0]   divisor_q;
  logic [DW-1:0]    dividend_q;
  logic [RW-1:0]    rem_q;
  logic [QW-1:0]    quot_q;
  logic [CW-1:0]    bit_cnt_q;
  logic [RANK_W-1:0] weight_q [MAX_GROUPS];

  logic [RW-1:0]     rem_sh;
  logic              rem_ge;
  logic [RW-1:0]     rem_d;
  logic [QW-1:0]     quot_d;
  logic [RANK_W-1:0] quot_sat;
  logic [RANK_W-1:0] weight_new;

  assign rem_sh     = {rem_q[RW-2:0], dividend_q[DW-1]};
  assign rem_ge     = rem_sh >= {1'b0, divisor_q};
  assign rem_d      = rem_ge ? (rem_sh - {1'b0, divisor_q}) : rem_sh;
  assign quot_d     = {quot_q[QW-2:0], rem_ge};
  assign quot_sat   = (|quot_d[QW-1:RANK_W]) ? ALL_ONES : quot_d[RANK_W-1:0];
  assign weight_new = (divisor_q == '0) ? ALL_ONES : quot_sat;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wst_q <= W_IDLE;
      grp_q <= '0;
      for (int i = 0; i < MAX_GROUPS; i++) begin
        weight_q[i] <= UNIT_W;
      end
    end else if (cfg_we_i) begin
      // restart the whole table on any register write
      wst_q <= W_LOAD;
      grp_q <= '0;
    end else begin
      unique case (wst_q)
        W_IDLE: ;
        W_LOAD: begin
          divisor_q  <= DVW'(group_count_q) * DVW'(group_size_q[3'(grp_q)]);
          dividend_q <= {total_count_q, {FRACTION_BITS{1'b0}}};
          rem_q      <= '0;
          quot_q     <= '0;
          bit_cnt_q  <= '0;
          wst_q      <= W_DIV;
        end
        W_DIV: begin
          rem_q      <= rem_d;
          quot_q     <= quot_d;
          dividend_q <= {dividend_q[DW-2:0], 1'b0};
          bit_cnt_q  <= bit_cnt_q + CW'(1);
          if (bit_cnt_q == CW'(DW - 1)) begin
            weight_q[grp_q] <= weight_new;
            if (grp_q == GIW'(MAX_GROUPS - 1)) begin
              wst_q <= W_IDLE;
            end else begin
              grp_q <= grp_q + GIW'(1);
              wst_q <= W_LOAD;
            end
          end
        end
        default: wst_q <= W_IDLE;
      endcase
    end
  end

  // --------------------------------------------------------------------------
  // Input register
  // --------------------------------------------------------------------------
  logic               in_vld_q;
  logic [VALUE_W-1:0] in_val_q;
  logic [LABEL_W-1:0] in_lab_q;
  logic               in_last_q;
  logic               proc_fire;
  logic [FPW:0]       cnt_q;

  assign proc_fire   = in_vld_q && (cnt_q <= (FPW+1)'(FD - 2));
  assign in_ch.ready = (wst_q == W_IDLE) && (!in_vld_q || proc_fire);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_vld_q <= 1'b0;
    end else if (in_ch.ready) begin
      in_vld_q <= in_ch.valid;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_ch.valid && in_ch.ready) begin
      in_val_q  <= in_ch.sample_value;
      in_lab_q  <= in_ch.group_label;
      in_last_q <= in_ch.last;
    end
  end

  // --------------------------------------------------------------------------
  // Run tracking: close the open run on a new value, add this sample's weight
  // --------------------------------------------------------------------------
  logic [RANK_W-1:0]   prior_sum_q;
  logic [RANK_W-1:0]   run_weight_q;
  logic [LENGTH_W-1:0] run_count_q;
  logic [VALUE_W-1:0]  run_value_q;
  logic                run_open_q;

  logic                run_close;
  logic                label_ok;
  logic [RANK_W-1:0]   sample_w;
  logic [RANK_W-1:0]   prior_next;
  logic [RANK_W-1:0]   rw_base;
  logic [LENGTH_W-1:0] rc_base;
  logic [RANK_W-1:0]   rw_next;
  logic [LENGTH_W-1:0] rc_next;
  result_t             res_closed;
  result_t             res_final;
  result_t             res_a;

  assign run_close = run_open_q && (in_val_q != run_value_q);
  assign label_ok  = (in_lab_q < group_count_q) && (32'(in_lab_q) < MAX_GROUPS);
  assign sample_w  = label_ok ? weight_q[in_lab_q[GIW-1:0]] : '0;

  assign prior_next = run_close ? sat_add(prior_sum_q, run_weight_q) : prior_sum_q;
  assign rw_base    = run_close ? '0 : run_weight_q;
  assign rc_base    = run_close ? '0 : run_count_q;
  assign rw_next    = sat_add(rw_base, sample_w);
  assign rc_next    = (rc_base < RUN_LIMIT) ? (rc_base + LENGTH_W'(1)) : rc_base;

  assign res_closed = '{pseudo_rank:   mid_rank(prior_sum_q, run_weight_q),
                        run_length:    run_count_q,
                        end_of_stream: 1'b0};
  assign res_final  = '{pseudo_rank:   mid_rank(prior_next, rw_next),
                        run_length:    rc_next,
                        end_of_stream: 1'b1};
  assign res_a      = run_close ? res_closed : res_final;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      prior_sum_q  <= '0;
      run_weight_q <= '0;
      run_count_q  <= '0;
      run_value_q  <= '0;
      run_open_q   <= 1'b0;
    end else if (proc_fire) begin
      if (in_last_q) begin
        // stream ends: drop all run state
        prior_sum_q  <= '0;
        run_weight_q <= '0;
        run_count_q  <= '0;
        run_value_q  <= '0;
        run_open_q   <= 1'b0;
      end else begin
        prior_sum_q  <= prior_next;
        run_weight_q <= rw_next;
        run_count_q  <= rc_next;
        run_value_q  <= in_val_q;
        run_open_q   <= 1'b1;
      end
    end
  end

  // --------------------------------------------------------------------------
  // Result queue: up to two pushes, one pop per cycle
  // --------------------------------------------------------------------------
  result_t        fifo_q [FD];
  logic [FPW-1:0] wptr_q;
  logic [FPW-1:0] rptr_q;
  logic [1:0]     push_n;
  logic           pop;

  assign push_n = proc_fire ? ({1'b0, run_close} + {1'b0, in_last_q}) : 2'd0;
  assign pop    = out_ch.valid && out_ch.ready;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wptr_q <= '0;
      rptr_q <= '0;
      cnt_q  <= '0;
    end else begin
      wptr_q <= wptr_q + FPW'(push_n);
      rptr_q <= rptr_q + FPW'(pop);
      cnt_q  <= cnt_q + (FPW+1)'(push_n) - (FPW+1)'(pop);
    end
  end

  always_ff @(posedge clk_i) begin
    if (push_n != 2'd0) begin
      fifo_q[wptr_q] <= res_a;
    end
    if (push_n == 2'd2) begin
      fifo_q[wptr_q + FPW'(1)] <= res_final;
    end
  end

  assign out_ch.valid         = (cnt_q != '0);
  assign out_ch.pseudo_rank   = fifo_q[rptr_q].pseudo_rank;
  assign out_ch.run_length    = fifo_q[rptr_q].run_length;
  assign out_ch.end_of_stream = fifo_q[rptr_q].end_of_stream;

endmodule

// ===== src/prms_checker.sv =====
// ----------------------------------------------------------------------------
// prms_checker: port-level checks of the mid pseudo-rank stream
// Watches the channels and the configuration port of the top level.
// ----------------------------------------------------------------------------
module prms_checker
  import prms_pkg::*;
(
  input logic                clk_i,
  input logic                rst_ni,
  input logic                cfg_we_i,
  input logic                in_valid_i,
  input logic                in_ready_i,
  input logic                out_valid_i,
  input logic                out_ready_i,
  input logic [RANK_W-1:0]   pseudo_rank_i,
  input logic [LENGTH_W-1:0] run_length_i,
  input logic                end_of_stream_i
);

  logic in_xfer;
  assign in_xfer = in_valid_i && in_ready_i;

  // hold a stalled result
  a_out_valid_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_i && !out_ready_i |=> out_valid_i)
    else $error("result valid dropped while stalled");

  a_out_data_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_i && !out_ready_i |=>
      $stable(pseudo_rank_i) && $stable(run_length_i) && $stable(end_of_stream_i))
    else $error("result payload changed while stalled");

  // a result out of an empty queue comes from a sample transfer through the input register
  a_out_from_in: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(out_valid_i) |-> $past(in_xfer, 2))
    else $error("result appeared without a sample transfer");

  // a register write starts the weight recompute, which stalls samples
  a_cfg_stall: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cfg_we_i |=> !in_ready_i)
    else $error("samples taken during weight recompute");

endmodule

bind pseudo_rank_midrank_stream prms_checker u_prms_checker (
  .clk_i           (clk_i),
  .rst_ni          (rst_ni),
  .cfg_we_i        (cfg_we_i),
  .in_valid_i      (in_ch.valid),
  .in_ready_i      (in_ch.ready),
  .out_valid_i     (out_ch.valid),
  .out_ready_i     (out_ch.ready),
  .pseudo_rank_i   (out_ch.pseudo_rank),
  .run_length_i    (out_ch.run_length),
  .end_of_stream_i (out_ch.end_of_stream)
);
